### sv/dgr_pkg.sv
// Shared types, constants and the CRC-32 byte step for the CAN datagram reassembler.
// Used by dgr_crc, dgr_store and can_datagram_reassembler; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dgr_pkg;

    // Payload store sizing
    localparam int MAX_PAYLOAD = 256;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int LEN_W       = 9;

    // Idle timeout register
    localparam int TIMEOUT_W = 31;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 31'd1000;

    // IEEE CRC-32, reflected
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Input operation codes
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TIME  = 1'b1;

    // Frame kind, low two bits of byte 0
    typedef enum logic [1:0] {
        KIND_MIDDLE = 2'd0,
        KIND_START  = 2'd1,
        KIND_END    = 2'd2,
        KIND_SINGLE = 2'd3
    } t_kind;

    // Result status codes
    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // Error kinds
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_TIMEOUT = 3'd1;
    localparam logic [2:0] ERR_SHORT   = 3'd2;
    localparam logic [2:0] ERR_LONG    = 3'd3;
    localparam logic [2:0] ERR_CRC     = 3'd4;

    typedef struct packed {
        logic        op;
        logic [3:0]  frame_len;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
        logic [7:0]  byte5;
        logic [7:0]  byte6;
        logic [7:0]  byte7;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [2:0]       error_kind;
        logic [LEN_W-1:0] payload_length;
        logic             last;
        logic [7:0]       out0;
        logic [7:0]       out1;
        logic [7:0]       out2;
        logic [7:0]       out3;
        logic [7:0]       out4;
        logic [7:0]       out5;
        logic [7:0]       out6;
        logic [7:0]       out7;
    } t_out_item;

    // Running CRC control
    typedef struct packed {
        logic       init;
        logic       upd;
        logic [7:0] data;
    } t_crc_ctl;

    // Payload store access, one write and one read port
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_store_req;

    // One byte through the reflected CRC-32, bit at a time
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### sv/dgr_crc.sv
// Running CRC-32 register, advanced one payload byte per cycle while an update is requested.
// Depends on dgr_pkg (t_crc_ctl, crc_byte, CRC_INIT).
`timescale 1ns / 1ps
`default_nettype none

module dgr_crc (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire dgr_pkg::t_crc_ctl i_ctl,
    output logic [31:0]           o_crc
);
    import dgr_pkg::*;

    logic [31:0] r_crc;
    logic [31:0] n_crc;

    // init wins over a byte update
    always_comb begin
        n_crc = r_crc;
        if (i_ctl.init) begin
            n_crc = CRC_INIT;
        end else if (i_ctl.upd) begin
            n_crc = crc_byte(r_crc, i_ctl.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

`default_nettype wire

### sv/dgr_store.sv
// Payload byte store: synchronous RAM, one write and one read port, registered read.
// Depends on dgr_pkg (t_store_req, MAX_PAYLOAD).
`timescale 1ns / 1ps
`default_nettype none

module dgr_store (
    input  wire logic                i_clk,
    input  wire dgr_pkg::t_store_req i_req,
    output logic [7:0]               o_rd_data
);
    import dgr_pkg::*;

    logic [7:0] r_mem [MAX_PAYLOAD];
    logic [7:0] r_rd_data;

    // Writes and reads never target the same cycle window (append vs. readout)
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### sv/can_datagram_reassembler.sv
// CAN datagram reassembler: control sequencer, timeout check, output register.
// Depends on dgr_pkg, dgr_crc and dgr_store.
//
// Each input transaction is one CAN frame (up to 8 bytes) or a time check, and
// produces one or more result transactions. A frame is latched and then decoded;
// each appended payload byte (up to 7) is written to the payload RAM and folded
// into the CRC-32 in the same cycle, and an end frame then has its CRC compared.
// A completed datagram is read back through the RAM's single read port, one byte
// per cycle, and each 8-byte result word waits for the output register to be free.
// Input is stalled while an item is in work; a final result may sit in the output
// register while the next input transaction is accepted.
`timescale 1ns / 1ps
`default_nettype none

module can_datagram_reassembler (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire dgr_pkg::t_in_item         i_in_data,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output dgr_pkg::t_out_item             o_out_data,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [dgr_pkg::TIMEOUT_W-1:0] i_cfg_data
);
    import dgr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_APPEND,
        S_CHECK,
        S_READ,
        S_RWAIT,
        S_EMIT
    } t_state;

    t_state                 r_state, n_state;
    t_in_item               r_item, n_item;
    logic [CNT_W-1:0]       r_fill, n_fill;
    logic [31:0]            r_expect, n_expect;
    logic                   r_inprog, n_inprog;
    logic [31:0]            r_last_t, n_last_t;
    logic [TIMEOUT_W-1:0]   r_timeout, n_timeout;
    logic [3:0]             r_idx, n_idx;
    logic [3:0]             r_end, n_end;
    logic                   r_is_end, n_is_end;
    t_out_item              r_res, n_res;
    t_out_item              r_out, n_out;
    logic                   r_out_valid, n_out_valid;
    logic [2:0]             r_lane, n_lane;
    logic [CNT_W-1:0]       r_base, n_base;
    logic                   r_pend_v, n_pend_v;
    logic [2:0]             r_pend_lane, n_pend_lane;
    logic                   r_pend_zero, n_pend_zero;

    t_crc_ctl               w_crc_ctl;
    logic [31:0]            w_crc;
    t_store_req             w_store;
    logic [7:0]             w_rd_data;

    logic [7:0]             w_b [8];
    logic [3:0]             w_flen;
    logic [3:0]             w_nbytes;
    t_kind                  w_kind;
    logic [31:0]            w_diff;
    logic                   w_timed;
    logic                   w_ovf;
    logic                   w_out_free;
    t_out_item              w_single;

    dgr_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_crc_ctl),
        .o_crc   (w_crc)
    );

    dgr_store u_store (
        .i_clk     (i_clk),
        .i_req     (w_store),
        .o_rd_data (w_rd_data)
    );

    // Result with header fields set and all payload bytes zero
    function automatic t_out_item make_hdr(input logic [1:0] st, input logic [2:0] ek,
                                           input logic [LEN_W-1:0] len, input logic lst);
        t_out_item r;
        r                = '0;
        r.status         = st;
        r.error_kind     = ek;
        r.payload_length = len;
        r.last           = lst;
        return r;
    endfunction

    // Place one byte at a word offset of a result
    function automatic t_out_item set_byte(input t_out_item res, input logic [2:0] lane,
                                           input logic [7:0] v);
        t_out_item r;
        r = res;
        unique case (lane)
            3'd0: r.out0 = v;
            3'd1: r.out1 = v;
            3'd2: r.out2 = v;
            3'd3: r.out3 = v;
            3'd4: r.out4 = v;
            3'd5: r.out5 = v;
            3'd6: r.out6 = v;
            3'd7: r.out7 = v;
        endcase
        return r;
    endfunction

    // Frame decode from the latched item
    assign w_b[0]   = r_item.byte0;
    assign w_b[1]   = r_item.byte1;
    assign w_b[2]   = r_item.byte2;
    assign w_b[3]   = r_item.byte3;
    assign w_b[4]   = r_item.byte4;
    assign w_b[5]   = r_item.byte5;
    assign w_b[6]   = r_item.byte6;
    assign w_b[7]   = r_item.byte7;
    assign w_flen   = (r_item.frame_len > 4'd8) ? 4'd8 : r_item.frame_len;
    assign w_nbytes = w_flen - 4'd1;
    assign w_kind   = t_kind'(r_item.byte0[1:0]);

    // Idle timeout: signed difference must be positive and above the limit
    assign w_diff  = r_item.now_ms - r_last_t;
    assign w_timed = r_inprog && (r_item.now_ms != 32'd0) && (r_last_t != 32'd0) &&
                     !w_diff[31] && (w_diff[30:0] > r_timeout);

    // Overflow if the append would pass the store size
    assign w_ovf = ({1'b0, r_fill} + (CNT_W+1)'(w_nbytes)) > (CNT_W+1)'(MAX_PAYLOAD);

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Single frame passes bytes 1..len-1 straight through
    always_comb begin
        w_single = make_hdr(ST_DONE, ERR_NONE, LEN_W'(w_nbytes), 1'b1);
        for (int i = 0; i < 7; i++) begin
            if (4'(i + 1) < w_flen) begin
                w_single = set_byte(w_single, 3'(i), w_b[i + 1]);
            end
        end
    end

    // Sequencer next state
    always_comb begin
        logic                 clr;
        logic [CNT_W:0]       rd_pos;
        logic [CNT_W:0]       nxt_base;

        n_state     = r_state;
        n_item      = r_item;
        n_fill      = r_fill;
        n_expect    = r_expect;
        n_inprog    = r_inprog;
        n_last_t    = r_last_t;
        n_timeout   = r_timeout;
        n_idx       = r_idx;
        n_end       = r_end;
        n_is_end    = r_is_end;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        n_lane      = r_lane;
        n_base      = r_base;
        n_pend_v    = 1'b0;
        n_pend_lane = r_pend_lane;
        n_pend_zero = r_pend_zero;
        w_crc_ctl   = '0;
        w_store     = '0;
        clr         = 1'b0;
        rd_pos      = {1'b0, r_base} + (CNT_W+1)'(r_lane);
        nxt_base    = {1'b0, r_base} + (CNT_W+1)'(8);

        // configuration register
        if (i_cfg_valid) begin
            n_timeout = i_cfg_data;
        end

        // read data returning from the store lands in the result word
        if (r_pend_v) begin
            n_res = set_byte(r_res, r_pend_lane, r_pend_zero ? 8'd0 : w_rd_data);
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_state = S_EMIT;
                n_res   = make_hdr(ST_NONE, ERR_NONE, '0, 1'b1);
                priority if (r_item.op == OP_TIME) begin
                    if (w_timed) begin
                        clr   = 1'b1;
                        n_res = make_hdr(ST_ERROR, ERR_TIMEOUT, LEN_W'(r_fill), 1'b1);
                    end
                end else if (w_flen == 4'd0) begin
                    // empty frame: nothing to do
                end else if (w_timed && (w_kind == KIND_MIDDLE || w_kind == KIND_END)) begin
                    clr   = 1'b1;
                    n_res = make_hdr(ST_ERROR, ERR_TIMEOUT, LEN_W'(r_fill), 1'b1);
                end else begin
                    unique case (w_kind)
                        KIND_SINGLE: begin
                            clr   = 1'b1;
                            n_res = w_single;
                        end
                        KIND_START: begin
                            if (w_flen < 4'd5) begin
                                clr   = 1'b1;
                                n_res = make_hdr(ST_ERROR, ERR_SHORT, '0, 1'b1);
                            end else begin
                                n_fill         = '0;
                                w_crc_ctl.init = 1'b1;
                                n_expect       = {r_item.byte4, r_item.byte3,
                                                  r_item.byte2, r_item.byte1};
                                n_inprog       = 1'b1;
                                if (r_item.now_ms != 32'd0) begin
                                    n_last_t = r_item.now_ms;
                                end
                                n_idx    = 4'd5;
                                n_end    = w_flen;
                                n_is_end = 1'b0;
                                if (w_flen > 4'd5) begin
                                    n_state = S_APPEND;
                                end
                            end
                        end
                        default: begin
                            // middle or end frame
                            if (r_inprog) begin
                                if (r_item.now_ms != 32'd0) begin
                                    n_last_t = r_item.now_ms;
                                end
                                if (w_ovf) begin
                                    clr   = 1'b1;
                                    n_res = make_hdr(ST_ERROR, ERR_LONG, LEN_W'(r_fill), 1'b1);
                                end else begin
                                    n_idx    = 4'd1;
                                    n_end    = w_flen;
                                    n_is_end = (w_kind == KIND_END);
                                    if (w_flen > 4'd1) begin
                                        n_state = S_APPEND;
                                    end else if (w_kind == KIND_END) begin
                                        n_state = S_CHECK;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end

            // one byte per cycle into the store and the CRC
            S_APPEND: begin
                w_store.we     = 1'b1;
                w_store.waddr  = r_fill[ADDR_W-1:0];
                w_store.wdata  = w_b[r_idx[2:0]];
                w_crc_ctl.upd  = 1'b1;
                w_crc_ctl.data = w_b[r_idx[2:0]];
                n_fill         = r_fill + CNT_W'(1);
                n_idx          = r_idx + 4'd1;
                if (r_idx + 4'd1 == r_end) begin
                    if (r_is_end) begin
                        n_state = S_CHECK;
                    end else begin
                        n_res   = make_hdr(ST_NONE, ERR_NONE, '0, 1'b1);
                        n_state = S_EMIT;
                    end
                end
            end

            // end frame: compare final CRC and start readout, or emit the error or empty result
            S_CHECK: begin
                if ((w_crc ^ CRC_INIT) != r_expect) begin
                    clr     = 1'b1;
                    n_res   = make_hdr(ST_ERROR, ERR_CRC, LEN_W'(r_fill), 1'b1);
                    n_state = S_EMIT;
                end else begin
                    n_inprog = 1'b0;
                    n_expect = '0;
                    n_last_t = '0;
                    if (r_fill == '0) begin
                        n_res   = make_hdr(ST_DONE, ERR_NONE, '0, 1'b1);
                        n_state = S_EMIT;
                    end else begin
                        n_base  = '0;
                        n_lane  = '0;
                        n_res   = make_hdr(ST_DONE, ERR_NONE, LEN_W'(r_fill),
                                           r_fill <= CNT_W'(8));
                        n_state = S_READ;
                    end
                end
            end

            // issue one store read per lane; past the end the lane reads as zero
            S_READ: begin
                w_store.re    = 1'b1;
                w_store.raddr = rd_pos[ADDR_W-1:0];
                n_pend_v      = 1'b1;
                n_pend_lane   = r_lane;
                n_pend_zero   = rd_pos >= {1'b0, r_fill};
                n_lane        = r_lane + 3'd1;
                if (r_lane == 3'd7) begin
                    n_state = S_RWAIT;
                end
            end

            S_RWAIT: begin
                n_state = S_EMIT;
            end

            // hand the result word to the output register
            S_EMIT: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    if (r_res.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_base     = nxt_base[CNT_W-1:0];
                        n_lane     = '0;
                        n_res.last = (nxt_base + (CNT_W+1)'(8)) >= {1'b0, r_fill};
                        n_state    = S_READ;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // abandon the datagram
        if (clr) begin
            n_fill         = '0;
            n_expect       = '0;
            n_inprog       = 1'b0;
            n_last_t       = '0;
            w_crc_ctl.init = 1'b1;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_item      <= '0;
            r_fill      <= '0;
            r_expect    <= '0;
            r_inprog    <= 1'b0;
            r_last_t    <= '0;
            r_timeout   <= TIMEOUT_RESET;
            r_idx       <= '0;
            r_end       <= '0;
            r_is_end    <= 1'b0;
            r_res       <= '0;
            r_out       <= '0;
            r_out_valid <= 1'b0;
            r_lane      <= '0;
            r_base      <= '0;
            r_pend_v    <= 1'b0;
            r_pend_lane <= '0;
            r_pend_zero <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_item      <= n_item;
            r_fill      <= n_fill;
            r_expect    <= n_expect;
            r_inprog    <= n_inprog;
            r_last_t    <= n_last_t;
            r_timeout   <= n_timeout;
            r_idx       <= n_idx;
            r_end       <= n_end;
            r_is_end    <= n_is_end;
            r_res       <= n_res;
            r_out       <= n_out;
            r_out_valid <= n_out_valid;
            r_lane      <= n_lane;
            r_base      <= n_base;
            r_pend_v    <= n_pend_v;
            r_pend_lane <= n_pend_lane;
            r_pend_zero <= n_pend_zero;
        end
    end

endmodule

`default_nettype wire

### bench/can_datagram_reassembler_tb.sv
// Self-checking bench for can_datagram_reassembler: frames in, 8-byte result words out.
// Depends on dgr_pkg and the reassembler RTL; predicts every result word internally.
`timescale 1ns / 1ps

module can_datagram_reassembler_tb;
    import dgr_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 20;
    localparam int LONG_HOLD    = 400;
    localparam int SHOW_MAX     = 10;

    typedef logic [7:0] t_bytes[$];

    // DUT connections
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in_item             in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [TIMEOUT_W-1:0] cfg_data  = '0;

    // Stimulus and scoreboard storage
    t_in_item    frames_to_send[$];
    t_out_item   expected_words[$];
    t_bytes      body_buf;
    int          items_queued  = 0;
    int          mismatches    = 0;
    int          cycle_count   = 0;
    int          send_idle_pct = 23;
    int          recv_idle_pct = 75;
    int          step_max      = 0;
    bit          allow_jumps   = 1'b0;
    logic [31:0] stim_ms       = 32'd0;
    bit          hold_req      = 1'b0;
    bit          hold_used     = 1'b0;
    int          hold_left     = 0;

    // Predicted block state
    logic [7:0]           dg_store[MAX_PAYLOAD];
    int                   dg_fill       = 0;
    logic [31:0]          dg_expect_crc = 32'd0;
    logic [31:0]          dg_crc        = CRC_INIT;
    bit                   dg_active     = 1'b0;
    logic [31:0]          dg_last_ms    = 32'd0;
    logic [TIMEOUT_W-1:0] idle_limit_ms = TIMEOUT_RESET;

    can_datagram_reassembler u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // CRC-32 (reflected), one byte
    function automatic logic [31:0] crc_fold(logic [31:0] acc, logic [7:0] b);
        acc ^= {24'd0, b};
        repeat (8) acc = (acc >> 1) ^ (CRC_POLY & {32{acc[0]}});
        return acc;
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    function automatic void drop_datagram();
        dg_fill       = 0;
        dg_expect_crc = 32'd0;
        dg_crc        = CRC_INIT;
        dg_active     = 1'b0;
        dg_last_ms    = 32'd0;
    endfunction

    function automatic void expect_status(logic [1:0] st, logic [2:0] kind, int len);
        t_out_item w;
        w                = '0;
        w.status         = st;
        w.error_kind     = kind;
        w.payload_length = LEN_W'(len);
        w.last           = 1'b1;
        expected_words   = {expected_words, w};
    endfunction

    // Completed payload, eight bytes per word, zero past the end
    function automatic void expect_payload(logic [7:0] src[MAX_PAYLOAD], int len);
        t_out_item  w;
        logic [7:0] v[8];
        if (len == 0) begin
            expect_status(ST_DONE, ERR_NONE, 0);
            return;
        end
        for (int off = 0; off < len; off += 8) begin
            for (int k = 0; k < 8; k++) v[k] = (off + k < len) ? src[off + k] : 8'h00;
            w                = '0;
            w.status         = ST_DONE;
            w.error_kind     = ERR_NONE;
            w.payload_length = LEN_W'(len);
            w.last           = (off + 8 >= len);
            {w.out0, w.out1, w.out2, w.out3} = {v[0], v[1], v[2], v[3]};
            {w.out4, w.out5, w.out6, w.out7} = {v[4], v[5], v[6], v[7]};
            expected_words = {expected_words, w};
        end
    endfunction

    // Idle limit check; clears the datagram when it fires
    function automatic bit idle_expired(logic [31:0] now, output int abandoned);
        logic [31:0] diff;
        abandoned = 0;
        if (!dg_active || now == 32'd0 || dg_last_ms == 32'd0) return 1'b0;
        diff = now - dg_last_ms;
        if (diff[31] || diff <= {1'b0, idle_limit_ms}) return 1'b0;
        abandoned = dg_fill;
        drop_datagram();
        return 1'b1;
    endfunction

    // Append b[from..to-1]; 0 on overflow (datagram dropped)
    function automatic bit store_bytes(logic [7:0] b[8], int from, int to);
        int n;
        n = to - from;
        if (n == 0) return 1'b1;
        if (dg_fill > MAX_PAYLOAD - n) begin
            drop_datagram();
            return 1'b0;
        end
        for (int i = from; i < to; i++) begin
            dg_crc            = crc_fold(dg_crc, b[i]);
            dg_store[dg_fill] = b[i];
            dg_fill++;
        end
        return 1'b1;
    endfunction

    function automatic void stamp_time(logic [31:0] now);
        if (now != 32'd0) dg_last_ms = now;
    endfunction

    // Expected result words for one accepted input transaction
    function automatic void reassemble(t_in_item it);
        logic [7:0] b[8];
        logic [7:0] single_data[MAX_PAYLOAD];
        int         flen;
        int         abandoned;
        int         fill_prior;
        int         total;
        bit         timed;
        t_kind      kind;
        b    = '{it.byte0, it.byte1, it.byte2, it.byte3, it.byte4, it.byte5, it.byte6,
                 it.byte7};
        flen = (it.frame_len > 4'd8) ? 8 : int'(it.frame_len);
        if (it.op == OP_TIME) begin
            if (idle_expired(it.now_ms, abandoned)) expect_status(ST_ERROR, ERR_TIMEOUT, abandoned);
            else expect_status(ST_NONE, ERR_NONE, 0);
            return;
        end
        if (flen == 0) begin
            expect_status(ST_NONE, ERR_NONE, 0);
            return;
        end
        kind  = t_kind'(it.byte0[1:0]);
        timed = idle_expired(it.now_ms, abandoned);
        // a timeout only wins over middle and end frames
        if (timed && kind != KIND_START && kind != KIND_SINGLE) begin
            expect_status(ST_ERROR, ERR_TIMEOUT, abandoned);
            return;
        end
        case (kind)
            KIND_SINGLE: begin
                drop_datagram();
                single_data = '{default: 8'h00};
                for (int i = 1; i < flen; i++) single_data[i - 1] = b[i];
                expect_payload(single_data, flen - 1);
            end
            KIND_START: begin
                if (flen < 5) begin
                    drop_datagram();
                    expect_status(ST_ERROR, ERR_SHORT, 0);
                end else begin
                    dg_fill       = 0;
                    dg_crc        = CRC_INIT;
                    dg_expect_crc = {b[4], b[3], b[2], b[1]};
                    dg_active     = 1'b1;
                    stamp_time(it.now_ms);
                    void'(store_bytes(b, 5, flen));
                    expect_status(ST_NONE, ERR_NONE, 0);
                end
            end
            default: begin
                if (!dg_active) begin
                    expect_status(ST_NONE, ERR_NONE, 0);
                    return;
                end
                stamp_time(it.now_ms);
                fill_prior = dg_fill;
                if (!store_bytes(b, 1, flen)) begin
                    expect_status(ST_ERROR, ERR_LONG, fill_prior);
                end else if (kind == KIND_MIDDLE) begin
                    expect_status(ST_NONE, ERR_NONE, 0);
                end else if (~dg_crc != dg_expect_crc) begin
                    total = dg_fill;
                    drop_datagram();
                    expect_status(ST_ERROR, ERR_CRC, total);
                end else begin
                    // fill count survives completion until the next start
                    dg_active     = 1'b0;
                    dg_expect_crc = 32'd0;
                    dg_last_ms    = 32'd0;
                    expect_payload(dg_store, dg_fill);
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Frame builders
    function automatic t_in_item rand_item();
        logic [127:0] r;
        r = {$urandom, $urandom, $urandom, $urandom};
        return r[$bits(t_in_item)-1:0];
    endfunction

    function automatic logic [7:0] kind_byte(t_kind kind);
        logic [7:0] v;
        v      = 8'($urandom);
        v[1:0] = kind;
        return v;
    endfunction

    function automatic void enqueue(t_in_item it);
        frames_to_send = {frames_to_send, it};
        items_queued++;
    endfunction

    function automatic void add_byte(logic [7:0] v);
        body_buf = {body_buf, v};
    endfunction

    function automatic void start_body(t_kind kind);
        body_buf = {};
        add_byte(kind_byte(kind));
    endfunction

    function automatic void add_random(int n);
        repeat (n) add_byte(8'($urandom));
    endfunction

    // Time for the next frame: mostly small steps, sometimes unknown or far off
    function automatic logic [31:0] next_now();
        int r;
        r = $urandom_range(99);
        if (r < 6) return 32'd0;
        if (allow_jumps && r < 10)
            stim_ms += {1'b0, idle_limit_ms} + 32'd1 + $urandom_range(300);
        else if (allow_jumps && r < 12)
            stim_ms += 32'h8000_0000 + $urandom_range(1000);
        else
            stim_ms += $urandom_range(step_max);
        return stim_ms;
    endfunction

    // Send body_buf as one CAN frame; a full frame may carry an oversized length
    function automatic void push_frame(logic [31:0] now);
        t_in_item it;
        logic [7:0] b[8];
        int n;
        it = rand_item();
        n  = body_buf.size();
        b  = '{it.byte0, it.byte1, it.byte2, it.byte3, it.byte4, it.byte5, it.byte6,
               it.byte7};
        for (int i = 0; i < n; i++) b[i] = body_buf[i];
        it.op        = OP_FRAME;
        it.frame_len = 4'(n);
        if (n == 8 && $urandom_range(5) == 0) it.frame_len = 4'($urandom_range(9, 15));
        {it.byte0, it.byte1, it.byte2, it.byte3} = {b[0], b[1], b[2], b[3]};
        {it.byte4, it.byte5, it.byte6, it.byte7} = {b[4], b[5], b[6], b[7]};
        it.now_ms = now;
        enqueue(it);
    endfunction

    function automatic void push_time(logic [31:0] now);
        t_in_item it;
        it        = rand_item();
        it.op     = OP_TIME;
        it.now_ms = now;
        enqueue(it);
    endfunction

    // Start, middles and end for a payload of len bytes
    function automatic void gen_datagram(int len, bit bad_crc);
        logic [7:0]  data[$];
        logic [31:0] crc;
        int          pos;
        int          chunk;
        crc = CRC_INIT;
        repeat (len) begin
            data = {data, 8'($urandom)};
            crc = crc_fold(crc, data[$]);
        end
        crc = ~crc;
        if (bad_crc) crc[$urandom_range(31)] ^= 1'b1;
        start_body(KIND_START);
        add_byte(crc[7:0]);
        add_byte(crc[15:8]);
        add_byte(crc[23:16]);
        add_byte(crc[31:24]);
        pos = 0;
        chunk = (len < 3) ? $urandom_range(len) : $urandom_range(3);
        repeat (chunk) begin
            add_byte(data[pos]);
            pos++;
        end
        push_frame(next_now());
        while (len - pos > 7 || (len - pos > 0 && $urandom_range(1) == 1)) begin
            chunk = $urandom_range(1, (len - pos > 7) ? 7 : len - pos);
            start_body(KIND_MIDDLE);
            repeat (chunk) begin
                add_byte(data[pos]);
                pos++;
            end
            push_frame(next_now());
        end
        start_body(KIND_END);
        while (pos < len) begin
            add_byte(data[pos]);
            pos++;
        end
        push_frame(next_now());
    endfunction

    // Mostly well-formed datagrams, the rest singles, time checks and noise
    function automatic void gen_random(int n);
        int target;
        int r;
        int len;
        t_in_item it;
        target = items_queued + n;
        while (items_queued < target) begin
            r = $urandom_range(99);
            if (r < 60) begin
                len = $urandom_range(99);
                if (len < 85) len = $urandom_range(24);
                else if (len < 97) len = $urandom_range(25, 100);
                else len = $urandom_range(180, MAX_PAYLOAD);
                gen_datagram(len, $urandom_range(9) == 0);
            end else if (r < 70) begin
                start_body(KIND_SINGLE);
                add_random($urandom_range(7));
                push_frame(next_now());
            end else if (r < 78) begin
                push_time(next_now());
            end else if (r < 84) begin
                start_body(KIND_START);
                add_random($urandom_range(3));
                push_frame(next_now());
            end else begin
                it           = rand_item();
                it.op        = OP_FRAME;
                it.now_ms    = next_now();
                enqueue(it);
            end
        end
    endfunction

    // Short hand-picked sequence: extremes, every frame kind, the timeout rules
    function automatic void gen_directed();
        t_in_item it;
        stim_ms = 32'd50;
        // zero-length frame is ignored; time check with nothing open
        it = rand_item();
        it.op = OP_FRAME;
        it.frame_len = 4'd0;
        it.now_ms = stim_ms;
        enqueue(it);
        push_time(stim_ms);
        // single frames: empty, full of ones, oversized length with zero bytes
        start_body(KIND_SINGLE);
        push_frame(stim_ms);
        body_buf = {};
        repeat (8) add_byte(8'hFF);
        push_frame(32'hFFFF_FFFF);
        it = '0;
        it.op = OP_FRAME;
        it.frame_len = 4'd15;
        it.byte0 = 8'(KIND_SINGLE);
        enqueue(it);
        // short start, then middle and end with nothing open
        start_body(KIND_START);
        add_random(3);
        push_frame(stim_ms);
        start_body(KIND_MIDDLE);
        add_random(2);
        push_frame(stim_ms);
        start_body(KIND_END);
        add_random(2);
        push_frame(stim_ms);
        // empty datagram, bad check, normal datagram
        gen_datagram(0, 1'b0);
        gen_datagram(5, 1'b1);
        gen_datagram(12, 1'b0);
        // limit reached exactly, then passed by one
        start_body(KIND_START);
        add_random(4);
        push_frame(32'd100);
        push_time(32'd1100);
        push_time(32'd1101);
        // middle frame after the limit
        start_body(KIND_START);
        add_random(7);
        push_frame(32'd2000);
        start_body(KIND_MIDDLE);
        add_random(4);
        push_frame(32'd3001);
        // single frame after the limit drops the timeout
        start_body(KIND_START);
        add_random(4);
        push_frame(32'd5000);
        start_body(KIND_SINGLE);
        add_random(3);
        push_frame(32'd9000);
        // unknown time, then a negative difference, then an end with a bad check
        start_body(KIND_START);
        add_random(5);
        push_frame(32'd10000);
        start_body(KIND_MIDDLE);
        add_random(6);
        push_frame(32'd0);
        push_time(32'd10000 + 32'h8000_0000);
        start_body(KIND_END);
        add_random(7);
        push_frame(32'd10010);
        stim_ms = 32'd20000;
    endfunction

    // ------------------------------------------------------------------
    // Sender: holds each transaction until accepted, predicts on acceptance
    always @(posedge clk) begin : drive_proc
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) reassemble(in_item);
            if (!in_valid || !in_stall) begin
                if (frames_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_item  <= frames_to_send.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls plus one long hold-off on request
    always @(posedge clk) begin : receiver_proc
        if (hold_req && !hold_used) begin
            hold_used = 1'b1;
            hold_left = LONG_HOLD;
        end else if (hold_left > 0) begin
            hold_left--;
        end
        out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
    end

    // Result checker
    function automatic logic [63:0] word_bytes(t_out_item w);
        return {w.out0, w.out1, w.out2, w.out3, w.out4, w.out5, w.out6, w.out7};
    endfunction

    function automatic void report_bad(string what, t_out_item want, t_out_item got);
        mismatches++;
        if (mismatches <= SHOW_MAX)
            $display("%0t %s: exp st=%0d err=%0d len=%0d last=%0d data=%h, ",
                     $realtime, what, want.status, want.error_kind, want.payload_length,
                     want.last, word_bytes(want),
                     "got st=%0d err=%0d len=%0d last=%0d data=%h",
                     got.status, got.error_kind, got.payload_length, got.last,
                     word_bytes(got));
    endfunction

    always @(posedge clk) begin : check_proc
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_words.size() == 0) begin
                report_bad("unexpected result", '0, out_item);
            end else begin
                want = expected_words.pop_front();
                if (want.status !== out_item.status || want.error_kind !== out_item.error_kind
                    || want.payload_length !== out_item.payload_length
                    || want.last !== out_item.last
                    || word_bytes(want) !== word_bytes(out_item))
                    report_bad("result mismatch", want, out_item);
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin : watchdog_proc
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[can_datagram_reassembler] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    task automatic wait_idle();
        do @(posedge clk);
        while (frames_to_send.size() != 0 || in_valid || expected_words.size() != 0);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_timeout(logic [TIMEOUT_W-1:0] v);
        wait_idle();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk);
        while (!cfg_ready);
        idle_limit_ms = v;
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        gen_directed();

        allow_jumps = 1'b1;
        write_timeout('0);
        step_max = 1;
        gen_random(12);
        write_timeout({TIMEOUT_W{1'b1}});
        step_max = 40;
        gen_random(12);

        send_idle_pct = 75;
        recv_idle_pct = 23;
        write_timeout(TIMEOUT_W'(1000));
        gen_random(20);
        write_timeout(TIMEOUT_W'(1));
        step_max = 3;
        gen_random(12);

        // no idling; receiver holds off while the sender keeps pushing
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_timeout(TIMEOUT_W'(250));
        step_max = 40;
        hold_req = 1'b1;
        allow_jumps = 1'b0;
        gen_datagram(MAX_PAYLOAD, 1'b0);
        gen_datagram(MAX_PAYLOAD + 1 + $urandom_range(10), 1'b0);
        allow_jumps = 1'b1;
        gen_random(10);

        wait_idle();
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("[can_datagram_reassembler] OK");
        end else begin
            $display("[can_datagram_reassembler] ERROR");
        end
        $finish;
    end

endmodule
